>>> rtl/smk_pkg.sv
// ----------------------------------------------------------------------------
// smk_pkg
// shared types, constants and the arctangent table for the swerve kinematics
// ----------------------------------------------------------------------------
package smk_pkg;

  localparam int TABLE_LEN = 24;
  localparam int DW        = 36;   // cordic datapath width
  localparam int ZW        = 33;   // angle accumulator width
  localparam logic signed [31:0] INV_GAIN_Q30   = 32'sd652032874;
  localparam logic signed [31:0] HALF_SQRT2_Q30 = 32'sd759250125;

  typedef enum logic [1:0] {
    REG_CHASSIS = 2'd0,
    REG_WHEEL   = 2'd1,
    REG_MINSPD  = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROT,
    ST_ROTFIX,
    ST_SPIN,
    ST_VEC,
    ST_VECFIX,
    ST_HEAD,
    ST_DIV,
    ST_NEXT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic vec_mode;
  } cordic_ctl_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    case (i)
      5'd0:  atan_turn = 32'd536870912;
      5'd1:  atan_turn = 32'd316933406;
      5'd2:  atan_turn = 32'd167458907;
      5'd3:  atan_turn = 32'd85004756;
      5'd4:  atan_turn = 32'd42667331;
      5'd5:  atan_turn = 32'd21354465;
      5'd6:  atan_turn = 32'd10679838;
      5'd7:  atan_turn = 32'd5340245;
      5'd8:  atan_turn = 32'd2670163;
      5'd9:  atan_turn = 32'd1335087;
      5'd10: atan_turn = 32'd667544;
      5'd11: atan_turn = 32'd333772;
      5'd12: atan_turn = 32'd166886;
      5'd13: atan_turn = 32'd83443;
      5'd14: atan_turn = 32'd41722;
      5'd15: atan_turn = 32'd20861;
      5'd16: atan_turn = 32'd10430;
      5'd17: atan_turn = 32'd5215;
      5'd18: atan_turn = 32'd2608;
      5'd19: atan_turn = 32'd1304;
      5'd20: atan_turn = 32'd652;
      5'd21: atan_turn = 32'd326;
      5'd22: atan_turn = 32'd163;
      5'd23: atan_turn = 32'd81;
      default: atan_turn = 32'd0;
    endcase
  endfunction

endpackage

>>> rtl/smk_cordic.sv
// ----------------------------------------------------------------------------
// smk_cordic
// one cordic micro-rotation per cycle, rotation or vectoring mode
// ----------------------------------------------------------------------------
module smk_cordic import smk_pkg::*; #(
  parameter int ITER = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cordic_ctl_t          ctl,
  input  logic signed [DW-1:0] x_in,
  input  logic signed [DW-1:0] y_in,
  input  logic signed [ZW-1:0] z_in,
  output logic signed [DW-1:0] x_out,
  output logic signed [DW-1:0] y_out,
  output logic signed [ZW-1:0] z_out,
  output logic                 done
);

  localparam int N = (ITER > TABLE_LEN) ? TABLE_LEN : ITER;

  logic signed [DW-1:0] x, y;
  logic signed [ZW-1:0] z;
  logic [4:0] i;
  logic       busy;
  logic       mode;
  logic       dir;
  logic signed [DW-1:0] dx, dy;
  logic signed [ZW-1:0] at;

  assign dx  = y >>> i;
  assign dy  = x >>> i;
  assign at  = ZW'(signed'({1'b0, atan_turn(i)}));
  assign dir = mode ? (y >= 0) : (z >= 0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      i    <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        x    <= x_in;
        y    <= y_in;
        z    <= z_in;
        mode <= ctl.vec_mode;
        i    <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (dir) begin
          x <= x - (mode ? -dx : dx);
          y <= y + (mode ? -dy : dy);
          z <= z - (mode ? -at : at);
        end else begin
          x <= x + (mode ? -dx : dx);
          y <= y - (mode ? -dy : dy);
          z <= z + (mode ? -at : at);
        end
        if (i == 5'(N - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        i <= i + 5'd1;
      end
    end
  end

  assign x_out = x;
  assign y_out = y;
  assign z_out = z;

endmodule

>>> rtl/smk_divider.sv
// ----------------------------------------------------------------------------
// smk_divider
// restoring divider, one quotient bit per cycle, rounds half away from zero
// ----------------------------------------------------------------------------
module smk_divider import smk_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [35:0] num,
  input  logic [9:0]  den,
  output logic [35:0] quo,
  output logic        done
);

  logic [35:0] q;
  logic [10:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [10:0] trial;

  assign trial = {rem[9:0], q[35]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q    <= num + 36'(den[9:1]);
        rem  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (trial >= {1'b0, den}) begin
          rem <= trial - {1'b0, den};
          q   <= {q[34:0], 1'b1};
        end else begin
          rem <= trial;
          q   <= {q[34:0], 1'b0};
        end
        if (cnt == 6'd35) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 6'd1;
      end
    end
  end

  assign quo = q;

endmodule

>>> rtl/swerve_module_kinematics_core.sv
// ----------------------------------------------------------------------------
// swerve_module_kinematics_core
// two-module swerve drive kinematics with a shared cordic and divider
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready) takes the velocity command, spin rate,
//   turret yaw and both measured steering angles once per control tick
//   output channel (out_valid/out_ready) returns both steering targets and
//   both wheel rates, one item per input item
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes chassis
//   radius, wheel radius and minimum speed; always ready
// sequence: one shared cordic runs three times (turret rotation, then each
//   module heading) and one bit-serial divider runs twice per item; in_ready
//   is low for the whole item, so a new item is taken only once the last
//   one has been loaded into the output register
// reset clears the stored headings, restores register defaults and empties
//   the output register; a stalled receiver holds the result in the output
//   register while the core works on the next item, which then waits in its
//   last step with in_ready low until the result is taken
// ----------------------------------------------------------------------------
module swerve_module_kinematics_core import smk_pkg::*; #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] vel_x_turret,
  input  logic signed [15:0] vel_y_turret,
  input  logic signed [15:0] spin_rate,
  input  logic [15:0]        turret_yaw,
  input  logic [15:0]        steer1_angle_meas,
  input  logic [15:0]        steer2_angle_meas,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        steer1_angle_cmd,
  output logic [15:0]        steer2_angle_cmd,
  output logic signed [15:0] wheel1_rate_cmd,
  output logic signed [15:0] wheel2_rate_cmd,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  // configuration registers
  logic [9:0] chassis_radius_mm;
  logic [7:0] wheel_radius_mm;
  logic [9:0] min_speed_mm_s;

  // heading state
  logic [15:0] steer1_heading;
  logic [15:0] steer2_heading;

  state_t state, state_next;

  // latched inputs and working values
  logic signed [15:0] spin;
  logic [15:0] meas1, meas2;
  logic signed [DW-1:0] xc, yc;      // body frame velocity, q8
  logic signed [DW-1:0] d;           // spin term
  logic signed [DW-1:0] mx, my;      // current module vector
  logic        mod_sel;              // 0 = module 1, 1 = module 2
  logic        vec_neg;              // vectoring half turn offset
  logic [15:0] ang;
  logic signed [DW-1:0] mag;
  logic        flip;
  logic [15:0] wheel1_rate;          // finished rates waiting for the output
  logic [15:0] wheel2_rate;
  logic        out_load;             // output register takes a new item

  // shared multiplier: 36 x 32 signed, registered
  logic signed [DW-1:0] mul_a;
  logic signed [31:0]   mul_b;
  logic signed [67:0]   mul_p;
  logic signed [67:0]   prod;

  // cordic
  cordic_ctl_t          cctl;
  logic signed [DW-1:0] c_xi, c_yi, c_xo, c_yo;
  logic signed [ZW-1:0] c_zi, c_zo;
  logic                 c_done;

  // divider
  logic        dv_start;
  logic [35:0] dv_num, dv_quo;
  logic        dv_done;
  logic [9:0]  dv_den;

  smk_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic (
    .clk, .rst, .ctl(cctl), .x_in(c_xi), .y_in(c_yi), .z_in(c_zi),
    .x_out(c_xo), .y_out(c_yo), .z_out(c_zo), .done(c_done)
  );

  smk_divider u_div (
    .clk, .rst, .start(dv_start), .num(dv_num), .den(dv_den),
    .quo(dv_quo), .done(dv_done)
  );

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_load  = (state == ST_OUT) && (!out_valid || out_ready);

  // rotation-mode fold: quadrants 1 and 2 negate the vector, add half turn
  logic [31:0]          yaw_a;
  logic                 yaw_fold;
  logic signed [DW-1:0] x256, y256;
  assign x256     = DW'(vel_x_turret) <<< 8;
  assign y256     = DW'(vel_y_turret) <<< 8;
  assign yaw_fold = (turret_yaw[15:14] == 2'd1) || (turret_yaw[15:14] == 2'd2);
  assign yaw_a    = {turret_yaw, 16'd0} + (yaw_fold ? 32'h8000_0000 : 32'd0);

  // gain-corrected value from the registered product
  logic signed [DW-1:0] fixed;
  assign fixed = DW'((prod + 68'sd536870912) >>> 30);

  // module vector components
  logic signed [DW-1:0] vx, vy, ax, ay;
  logic signed [DW+1:0] thr;
  assign vx  = mod_sel ? (xc + d) : (xc - d);
  assign vy  = mod_sel ? (yc - d) : (yc + d);
  assign ax  = (vx < 0) ? -vx : vx;
  assign ay  = (vy < 0) ? -vy : vy;
  assign thr = (DW+2)'({min_speed_mm_s, 8'd0});

  // heading decision
  logic [15:0] vang, head_cur, head_new, diff;
  logic        upd, fl;
  assign vang     = 16'(((vec_neg ? 32'h8000_0000 : 32'd0) + 32'(c_zo) + 32'h8000) >> 16);
  assign head_cur = mod_sel ? steer2_heading : steer1_heading;
  assign upd      = ((DW+2)'(ax) > thr) || ((DW+2)'(ay) > thr);
  assign head_new = upd ? ang : head_cur;
  assign diff     = head_new - (mod_sel ? meas2 : meas1);
  assign fl       = (diff > 16'd16384) && (diff < 16'd49152);

  logic signed [DW-1:0] amag;
  logic signed [DW:0]   rate;
  logic [15:0]          rate_sat;
  assign amag = (mag < 0) ? -mag : mag;
  assign dv_num = 36'(amag);
  assign dv_den = {(wheel_radius_mm == 8'd0) ? 8'd1 : wheel_radius_mm, 2'b00};
  assign rate = ((mag < 0) != flip) ? -(DW+1)'(signed'({1'b0, dv_quo}))
                                    : (DW+1)'(signed'({1'b0, dv_quo}));
  always_comb begin
    if (rate > 37'sd32767)       rate_sat = 16'h7FFF;
    else if (rate < -37'sd32768) rate_sat = 16'h8000;
    else                         rate_sat = rate[15:0];
  end

  // sequencer
  logic [1:0] sub;   // small step counter within the fix, spin and vector states

  // multiplier operand select
  always_comb begin
    mul_a = c_xo;
    mul_b = INV_GAIN_Q30;
    case (state)
      ST_ROTFIX: mul_a = (sub == 2'd0) ? c_xo : c_yo;
      ST_SPIN:   begin
        // spin times radius first, then the 45 degree factor
        if (sub == 2'd0) begin
          mul_a = DW'(spin);
          mul_b = 32'(signed'({1'b0, chassis_radius_mm}));
        end else begin
          mul_a = DW'(prod);
          mul_b = HALF_SQRT2_Q30;
        end
      end
      default:   mul_a = c_xo;
    endcase
  end
  assign mul_p = 68'(mul_a) * 68'(mul_b);

  always_comb begin
    state_next = state;
    cctl       = '0;
    c_xi       = '0;
    c_yi       = '0;
    c_zi       = '0;
    dv_start   = 1'b0;
    case (state)
      ST_IDLE: if (in_valid && in_ready) begin
        cctl.start = 1'b1;
        c_xi = yaw_fold ? -x256 : x256;
        c_yi = yaw_fold ? -y256 : y256;
        c_zi = ZW'(signed'(yaw_a));
        state_next = ST_ROT;
      end
      ST_ROT:    if (c_done) state_next = ST_ROTFIX;
      ST_ROTFIX: if (sub == 2'd3) state_next = ST_SPIN;
      ST_SPIN:   if (sub == 2'd2) state_next = ST_VEC;
      ST_VEC: begin
        if (sub == 2'd0) begin
          cctl.start    = 1'b1;
          cctl.vec_mode = 1'b1;
          c_xi = (vx < 0) ? -vx : vx;
          c_yi = (vx < 0) ? -vy : vy;
        end else if (c_done) state_next = ST_VECFIX;
      end
      ST_VECFIX: if (sub == 2'd1) state_next = ST_HEAD;
      ST_HEAD: begin
        dv_start   = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV:  if (dv_done) state_next = ST_NEXT;
      ST_NEXT: state_next = mod_sel ? ST_OUT : ST_VEC;
      ST_OUT:  if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_p;
    if (rst) begin
      chassis_radius_mm <= 10'd300;
      wheel_radius_mm   <= 8'd76;
      min_speed_mm_s    <= 10'd10;
      steer1_heading    <= '0;
      steer2_heading    <= '0;
      out_valid         <= 1'b0;
      sub               <= '0;
      mod_sel           <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CHASSIS: chassis_radius_mm <= cfg_data[9:0];
          REG_WHEEL:   wheel_radius_mm   <= cfg_data[7:0];
          REG_MINSPD:  min_speed_mm_s    <= cfg_data[9:0];
          default:     ;
        endcase
      end
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: if (in_valid && in_ready) begin
          spin    <= spin_rate;
          meas1   <= steer1_angle_meas;
          meas2   <= steer2_angle_meas;
          mod_sel <= 1'b0;
          sub     <= '0;
        end
        ST_ROTFIX: begin
          // sub 0: x product issued; 1: x ready, y issued; 2: y ready
          if (sub == 2'd1) xc <= fixed;
          if (sub == 2'd2) yc <= fixed;
          sub <= (sub == 2'd3) ? 2'd0 : sub + 2'd1;
        end
        ST_SPIN: begin
          if (sub == 2'd2) begin
            d   <= DW'((prod + 68'sd2147483648) >>> 32);
            sub <= 2'd0;
          end else sub <= sub + 2'd1;
        end
        ST_VEC: begin
          if (sub == 2'd0) begin
            vec_neg <= (vx < 0);
            sub     <= 2'd1;
          end else if (c_done) sub <= 2'd0;
        end
        ST_VECFIX: begin
          if (sub == 2'd0) begin
            ang <= vang;
            sub <= 2'd1;
          end else begin
            mag <= fixed;
            sub <= 2'd0;
          end
        end
        ST_HEAD: begin
          flip <= fl;
          if (mod_sel) steer2_heading <= fl ? head_new + 16'h8000 : head_new;
          else         steer1_heading <= fl ? head_new + 16'h8000 : head_new;
        end
        ST_NEXT: begin
          if (mod_sel) wheel2_rate <= rate_sat;
          else         wheel1_rate <= rate_sat;
          mod_sel <= 1'b1;
        end
        ST_OUT: begin
          if (out_load) begin
            steer1_angle_cmd <= steer1_heading;
            steer2_angle_cmd <= steer2_heading;
            wheel1_rate_cmd  <= wheel1_rate;
            wheel2_rate_cmd  <= wheel2_rate;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> tb/swerve_module_kinematics_core_tb.sv
// ----------------------------------------------------------------------------
// swerve_module_kinematics_core_tb
// self-checking bench for the two-module swerve kinematics core: each accepted
// command is run through a bit-exact fixed-point predictor with its own copy
// of the registers and stored headings, and every returned item is compared
// field by field with the oldest prediction
// ----------------------------------------------------------------------------
module swerve_module_kinematics_core_tb;
  import smk_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITERATIONS  = 16;
  localparam int SETTLE      = 200;    // a bit above the core latency
  localparam int HOLD_CYCLES = 400;    // long receiver hold-off
  localparam int IDLE_LIMIT  = 5000;   // cycles without any handshake

  // command going in
  typedef struct {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] spin;
    logic [15:0]        yaw;
    logic [15:0]        meas1;
    logic [15:0]        meas2;
  } drive_cmd_t;

  // targets coming out
  typedef struct {
    logic [15:0]        ang1;
    logic [15:0]        ang2;
    logic signed [15:0] rate1;
    logic signed [15:0] rate2;
  } wheel_cmd_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] vel_x_turret;
  logic signed [15:0] vel_y_turret;
  logic signed [15:0] spin_rate;
  logic [15:0]        turret_yaw;
  logic [15:0]        steer1_angle_meas;
  logic [15:0]        steer2_angle_meas;
  logic               out_valid;
  logic               out_ready;
  logic [15:0]        steer1_angle_cmd;
  logic [15:0]        steer2_angle_cmd;
  logic signed [15:0] wheel1_rate_cmd;
  logic signed [15:0] wheel2_rate_cmd;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;

  swerve_module_kinematics_core #(.CORDIC_ITERATIONS(ITERATIONS)) u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .vel_x_turret     (vel_x_turret),
    .vel_y_turret     (vel_y_turret),
    .spin_rate        (spin_rate),
    .turret_yaw       (turret_yaw),
    .steer1_angle_meas(steer1_angle_meas),
    .steer2_angle_meas(steer2_angle_meas),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .steer1_angle_cmd (steer1_angle_cmd),
    .steer2_angle_cmd (steer2_angle_cmd),
    .wheel1_rate_cmd  (wheel1_rate_cmd),
    .wheel2_rate_cmd  (wheel2_rate_cmd),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // 20 ns clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // ---------------------------------------------------------------------------
  // predictor state: registers and stored headings, mirrored in the bench
  // ---------------------------------------------------------------------------
  int unsigned chassis_mm;
  int unsigned wheel_mm;
  int unsigned min_speed;
  bit [15:0]   heading1;
  bit [15:0]   heading2;

  wheel_cmd_t  expected_wheel_cmds[$];
  int          error_count;
  bit          quiet;        // no idling on either side
  bit          hold_req;     // ask the receiver for a long hold-off

  // arctangent per iteration, full turn = 2^32
  const longint arctan_step[24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  function automatic int cordic_steps();
    return (ITERATIONS > 24) ? 24 : ITERATIONS;
  endfunction

  // cordic gain removal with rounding, floor shift
  function automatic longint remove_gain(longint v);
    return (v * 64'sd652032874 + 64'sd536870912) >>> 30;
  endfunction

  // turret frame to body frame rotation
  function automatic void turret_to_body(inout longint x, inout longint y,
                                         input bit [15:0] yaw);
    bit [31:0] a;
    longint    z;
    longint    dx;
    longint    dy;
    a = {yaw, 16'h0000};
    // second and third quadrant: turn the vector around first
    if (a[31:30] == 2'd1 || a[31:30] == 2'd2) begin
      x = -x;
      y = -y;
      a = a + 32'h8000_0000;
    end
    z = longint'(signed'(a));
    for (int i = 0; i < cordic_steps(); i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - arctan_step[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + arctan_step[i];
      end
    end
    x = remove_gain(x);
    y = remove_gain(y);
  endfunction

  // heading and length of a vector
  function automatic void to_polar(input longint xi, input longint yi,
                                   output bit [15:0] ang, output longint mag);
    longint    x;
    longint    y;
    longint    z;
    longint    dx;
    longint    dy;
    bit [31:0] off;
    bit [31:0] zz;
    x   = xi;
    y   = yi;
    z   = 0;
    off = 32'h0;
    if (x < 0) begin
      x   = -x;
      y   = -y;
      off = 32'h8000_0000;
    end
    for (int i = 0; i < cordic_steps(); i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + arctan_step[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - arctan_step[i];
      end
    end
    zz  = off + z[31:0] + 32'h0000_8000;
    ang = zz[31:16];
    mag = remove_gain(x);
  endfunction

  function automatic longint abs_val(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // one steering module: heading hold, flip test, wheel rate
  function automatic void steer_module(input longint x, input longint y,
                                       input bit [15:0] meas,
                                       inout bit [15:0] heading,
                                       output bit [15:0] ang_cmd,
                                       output bit [15:0] rate_cmd);
    longint    thr;
    longint    mag;
    longint    den;
    longint    r;
    bit [15:0] ang;
    bit [15:0] diff;
    bit        flip;
    thr = longint'(min_speed) * 256;
    to_polar(x, y, ang, mag);
    if (abs_val(x) > thr || abs_val(y) > thr) heading = ang;
    diff = heading - meas;
    flip = (diff > 16'd16384) && (diff < 16'd49152);
    if (flip) heading = heading + 16'h8000;
    den = 4 * longint'((wheel_mm == 0) ? 1 : wheel_mm);
    r = (abs_val(mag) + den / 2) / den;
    if ((mag < 0) != flip) r = -r;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    ang_cmd  = heading;
    rate_cmd = r[15:0];
  endfunction

  // full prediction for one accepted command, updates stored headings
  function automatic wheel_cmd_t predict_wheel_cmds(drive_cmd_t c);
    wheel_cmd_t w;
    longint     x;
    longint     y;
    longint     d;
    bit [15:0]  a;
    bit [15:0]  r;
    x = longint'(c.vx) * 256;
    y = longint'(c.vy) * 256;
    turret_to_body(x, y, c.yaw);
    // spin contribution at 45 degrees per module
    d = (longint'(c.spin) * longint'(chassis_mm) * 64'sd759250125
         + 64'sd2147483648) >>> 32;
    steer_module(x - d, y + d, c.meas1, heading1, a, r);
    w.ang1  = a;
    w.rate1 = r;
    steer_module(x + d, y - d, c.meas2, heading2, a, r);
    w.ang2  = a;
    w.rate2 = r;
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // offer one command from a falling edge, hold until taken
  task automatic send_cmd(drive_cmd_t c);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid          = 1'b1;
    vel_x_turret      = c.vx;
    vel_y_turret      = c.vy;
    spin_rate         = c.spin;
    turret_yaw        = c.yaw;
    steer1_angle_meas = c.meas1;
    steer2_angle_meas = c.meas2;
    do @(posedge clk); while (!in_ready);
    expected_wheel_cmds.push_back(predict_wheel_cmds(c));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic drive_cmd_t make_cmd(int vx, int vy, int spin, int yaw,
                                          int m1, int m2);
    drive_cmd_t c;
    c.vx    = vx[15:0];
    c.vy    = vy[15:0];
    c.spin  = spin[15:0];
    c.yaw   = yaw[15:0];
    c.meas1 = m1[15:0];
    c.meas2 = m2[15:0];
    return c;
  endfunction

  // mix of full-range commands, slow ones near the heading threshold, mid-range ones and pure spin
  function automatic drive_cmd_t random_cmd();
    drive_cmd_t c;
    int         lim;
    c.yaw   = 16'($urandom);
    c.meas1 = 16'($urandom);
    c.meas2 = 16'($urandom);
    case ($urandom_range(0, 3))
      0: begin
        c.vx   = 16'($urandom);
        c.vy   = 16'($urandom);
        c.spin = 16'($urandom);
      end
      1: begin
        // around the threshold, so some headings are held
        lim    = int'(min_speed) + 3;
        c.vx   = 16'($urandom_range(0, 2 * lim) - lim);
        c.vy   = 16'($urandom_range(0, 2 * lim) - lim);
        c.spin = 16'($urandom_range(0, 16) - 8);
      end
      2: begin
        c.vx   = 16'($urandom_range(0, 4000) - 2000);
        c.vy   = 16'($urandom_range(0, 4000) - 2000);
        c.spin = 16'($urandom_range(0, 8000) - 4000);
      end
      default: begin
        // pure spin, module vectors pointing opposite ways
        c.vx   = 16'h0;
        c.vy   = 16'h0;
        c.spin = 16'($urandom);
      end
    endcase
    return c;
  endfunction

  // register write, for use only while the core is idle; the task does not check
  task automatic write_reg(reg_idx_t idx, int unsigned value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value[15:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CHASSIS: chassis_mm = value & 32'h3FF;
      REG_WHEEL:   wheel_mm   = value & 32'hFF;
      REG_MINSPD:  min_speed  = value & 32'h3FF;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // wait for every outstanding item, then let the core settle
  task automatic drain();
    while (expected_wheel_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_regs(int unsigned chassis, int unsigned wheel,
                          int unsigned minspd);
    drain();
    write_reg(REG_CHASSIS, chassis);
    write_reg(REG_WHEEL, wheel);
    write_reg(REG_MINSPD, minspd);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // zero velocity walks the held heading across the flip borders, then slow commands probe the threshold
  task automatic test_flip_borders();
    send_cmd(make_cmd(0, 0, 0, 0, 0, 0));          // held heading zero
    send_cmd(make_cmd(0, 0, 0, 0, 16384, 49152));  // exactly 90 degrees, no flip
    send_cmd(make_cmd(0, 0, 0, 0, 16383, 49153));  // just inside on the other side
    send_cmd(make_cmd(0, 0, 0, 0, 16385, 49151));  // just past 90, both flip
    send_cmd(make_cmd(0, 0, 0, 0, 0, 0));          // half turn apart, flips back
    send_cmd(make_cmd(10, -10, 0, 0, 0, 0));       // at threshold, still held
    send_cmd(make_cmd(11, 0, 0, 0, 0, 0));         // just above threshold
  endtask

  // field extremes, yaw quadrants and spin limits
  task automatic test_extremes();
    send_cmd(make_cmd(32767, 32767, 32767, 65535, 65535, 65535));
    send_cmd(make_cmd(-32768, -32768, -32768, 0, 0, 0));
    send_cmd(make_cmd(32767, -32768, 0, 16384, 16384, 16384));
    send_cmd(make_cmd(-32768, 32767, 0, 32768, 32768, 32768));
    send_cmd(make_cmd(1000, 0, 0, 49152, 49152, 0));
    send_cmd(make_cmd(1000, 0, 0, 16383, 0, 0));
    send_cmd(make_cmd(0, 1000, 0, 32767, 0, 0));
    send_cmd(make_cmd(0, 0, 32767, 0, 0, 0));
    send_cmd(make_cmd(0, 0, -32768, 0, 8192, 40960));
    send_cmd(make_cmd(-1, -1, -1, 1, 1, 1));
  endtask

  // small wheel radius with a large chassis saturates, a large threshold holds headings
  task automatic test_register_extremes();
    set_regs(1023, 1, 0);
    send_cmd(make_cmd(32767, 0, 32767, 0, 0, 0));
    send_cmd(make_cmd(-32768, 100, -32768, 0, 32768, 32768));
    send_cmd(make_cmd(0, 0, 0, 0, 0, 0));
    set_regs(1, 255, 1023);
    send_cmd(make_cmd(1023, -1023, 5, 4096, 30000, 0));
    send_cmd(make_cmd(1024, 0, 0, 0, 0, 0));
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_cmd(random_cmd());
  endtask

  // receiver holds off for a long stretch while commands keep coming
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 20; i++) send_cmd(random_cmd());
  endtask

  // ---------------------------------------------------------------------------
  // receiver side: ready pattern at the falling edge
  // ---------------------------------------------------------------------------
  int hold_cnt;
  int stall_cnt;

  always @(negedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt--;
      out_ready = 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_cnt  = HOLD_CYCLES - 1;
      out_ready = 1'b0;
    end else if (stall_cnt != 0) begin
      stall_cnt--;
      out_ready = 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_cnt = $urandom_range(1, 9) - 1;
      out_ready = 1'b0;
    end else begin
      out_ready = 1'b1;
    end
  end

  // result check against the oldest prediction
  always @(posedge clk) begin
    wheel_cmd_t w;
    if (!rst && out_valid && out_ready) begin
      if (expected_wheel_cmds.size() == 0) begin
        $display("%0t: unexpected item ang1=%0d ang2=%0d rate1=%0d rate2=%0d",
                 $time, steer1_angle_cmd, steer2_angle_cmd,
                 wheel1_rate_cmd, wheel2_rate_cmd);
        error_count++;
      end else begin
        w = expected_wheel_cmds.pop_front();
        if (steer1_angle_cmd !== w.ang1) begin
          $display("%0t: steer1_angle_cmd expected %0d got %0d",
                   $time, w.ang1, steer1_angle_cmd);
          error_count++;
        end
        if (steer2_angle_cmd !== w.ang2) begin
          $display("%0t: steer2_angle_cmd expected %0d got %0d",
                   $time, w.ang2, steer2_angle_cmd);
          error_count++;
        end
        if (wheel1_rate_cmd !== w.rate1) begin
          $display("%0t: wheel1_rate_cmd expected %0d got %0d",
                   $time, w.rate1, wheel1_rate_cmd);
          error_count++;
        end
        if (wheel2_rate_cmd !== w.rate2) begin
          $display("%0t: wheel2_rate_cmd expected %0d got %0d",
                   $time, w.rate2, wheel2_rate_cmd);
          error_count++;
        end
      end
    end
  end

  // watchdog: any handshake resets the count
  int idle_cycles;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[swerve_module_kinematics_core] ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst               = 1'b1;
    in_valid          = 1'b0;
    out_ready         = 1'b0;
    cfg_valid         = 1'b0;
    cfg_index         = REG_CHASSIS;
    cfg_data          = 16'h0;
    vel_x_turret      = 16'sh0;
    vel_y_turret      = 16'sh0;
    spin_rate         = 16'sh0;
    turret_yaw        = 16'h0;
    steer1_angle_meas = 16'h0;
    steer2_angle_meas = 16'h0;
    quiet             = 1'b0;
    hold_req          = 1'b0;
    hold_cnt          = 0;
    stall_cnt         = 0;
    error_count       = 0;
    idle_cycles       = 0;
    // reset defaults
    chassis_mm = 300;
    wheel_mm   = 76;
    min_speed  = 10;
    heading1   = 16'h0;
    heading2   = 16'h0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_flip_borders();
    test_extremes();
    test_register_extremes();

    set_regs(300, 76, 10);
    test_random(250);
    test_backpressure();
    set_regs(1, 1, 0);
    test_random(250);
    set_regs(1023, 255, 1023);
    test_random(250);
    set_regs(512, 128, 3);
    test_random(250);
    set_regs($urandom_range(1, 1023), $urandom_range(1, 255), $urandom_range(0, 64));
    test_random(220);

    // closing stretch without idling on either side
    quiet = 1'b1;
    test_random(100);

    drain();
    if (error_count == 0) begin
      $display("[swerve_module_kinematics_core] OK");
    end else begin
      $display("[swerve_module_kinematics_core] ERROR");
    end
    $finish;
  end

endmodule
